// File: hdl/stp_pkg.sv
// stp_pkg: shared types and constants for the half-step out-and-back sequencer
// holds the transfer payload structs, operation and direction codes, coil table
// no dependencies
package stp_pkg;

    localparam int unsigned FIELD_W = 24;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned COIL_W  = 4;

    // operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_MOVE = 1'b1;

    // direction as two-bit signed value
    typedef logic [1:0] t_dir;
    localparam t_dir DIR_ZERO = 2'b00;
    localparam t_dir DIR_FWD  = 2'b01;
    localparam t_dir DIR_REV  = 2'b11;

    // half-step coil patterns, bit3 = A .. bit0 = D
    localparam logic [COIL_W-1:0] HALF_STEP_TABLE [8] = '{
        4'd1, 4'd3, 4'd2, 4'd6, 4'd4, 4'd12, 4'd8, 4'd9
    };

    typedef struct packed {
        logic                      operation;
        logic signed [FIELD_W-1:0] revolutions;
    } t_in_item;

    typedef struct packed {
        logic [COIL_W-1:0] coil_pattern;
        logic              busy_res;
        logic              accepted;
    } t_out_item;

endpackage

// File: hdl/stepper_half_step_out_and_back.sv
// stepper_half_step_out_and_back: top level of the half-step out-and-back sequencer
// input register, step_scale register, result register around stp_core
// depends on stp_pkg, stp_core
//
// usage:
//   input channel carries an operation (timer tick or move command) and a signed
//   Q8.16 angle; every transfer yields exactly one result on the output channel
//   with the coil pattern, the busy flag and whether a move was started.
//   the config channel writes step_scale (unsigned Q16.8); it is always ready and
//   should only be written while the block is idle.
// path: an input transfer lands in the input register, then the update and
//   multiply land in the result register.
// throughput: 1 item per cycle while results are taken; the input register
//   refills while a finished result waits; 24x24 multiply + state update is the one stage.
// stall: when the receiver holds ready low, the result register holds; the input
//   register takes one more item, then ready drops until the result moves.
// reset: synchronous active low; coils off, idle, step_scale back to 16.0,
//   both pipeline registers empty.
module stepper_half_step_out_and_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  stp_pkg::t_in_item           i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output stp_pkg::t_out_item          o_out_item,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [stp_pkg::FIELD_W-1:0] i_cfg_data
);

    localparam logic [stp_pkg::FIELD_W-1:0] SCALE_RESET = 24'd4096;

    logic                        r_in_valid;
    stp_pkg::t_in_item           r_in_item;
    logic                        r_out_valid;
    stp_pkg::t_out_item          r_out_item;
    logic [stp_pkg::FIELD_W-1:0] r_step_scale;
    logic                        advance;
    logic                        in_xfer;
    stp_pkg::t_out_item          result;

    // pipeline control
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    stp_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (advance),
        .i_item       (r_in_item),
        .i_step_scale (r_step_scale),
        .o_result     (result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_item <= i_in_item;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= result;
        end
    end

    // step_scale register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_scale <= SCALE_RESET;
        end else if (i_cfg_valid) begin
            r_step_scale <= i_cfg_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// File: hdl/stp_core.sv
// stp_core: sequencer state and the single-pass update for one item
// depends on stp_pkg
module stp_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  stp_pkg::t_in_item             i_item,
    input  logic [stp_pkg::FIELD_W-1:0]   i_step_scale,
    output stp_pkg::t_out_item            o_result
);

    logic                          r_running,     n_running;
    logic                          r_reverse,     n_reverse;
    logic [stp_pkg::PHASE_W-1:0]   r_phase,       n_phase;
    stp_pkg::t_dir                 r_dir,         n_dir;
    logic [stp_pkg::FIELD_W-1:0]   r_step_target, n_step_target;
    logic [stp_pkg::FIELD_W-1:0]   r_step_done,   n_step_done;
    logic [stp_pkg::COIL_W-1:0]    r_coil,        n_coil;

    logic [stp_pkg::FIELD_W-1:0]   raw;
    logic                          neg;
    logic [stp_pkg::FIELD_W-1:0]   mag;
    logic [2*stp_pkg::FIELD_W-1:0] prod;
    logic [stp_pkg::FIELD_W-1:0]   count;
    logic                          accepted;

    // step count: |revolutions| * scale, integer part of Q24.24
    assign raw   = i_item.revolutions;
    assign neg   = raw[stp_pkg::FIELD_W-1];
    assign mag   = neg ? (stp_pkg::FIELD_W'(0) - raw) : raw;
    assign prod  = (2*stp_pkg::FIELD_W)'(mag) * (2*stp_pkg::FIELD_W)'(i_step_scale);
    assign count = prod[2*stp_pkg::FIELD_W-1:stp_pkg::FIELD_W];

    // next state for the item in the input register
    always_comb begin
        n_running     = r_running;
        n_reverse     = r_reverse;
        n_phase       = r_phase;
        n_dir         = r_dir;
        n_step_target = r_step_target;
        n_step_done   = r_step_done;
        n_coil        = r_coil;
        accepted      = 1'b0;
        if (i_fire) begin
            if (i_item.operation == stp_pkg::OP_MOVE) begin
                if (!r_running) begin
                    n_step_target = count;
                    if (count == '0) begin
                        n_dir = stp_pkg::DIR_ZERO;
                    end else if (neg) begin
                        n_dir = stp_pkg::DIR_REV;
                    end else begin
                        n_dir = stp_pkg::DIR_FWD;
                    end
                    n_step_done = '0;
                    n_phase     = '0;
                    n_reverse   = 1'b0;
                    n_running   = 1'b1;
                    accepted    = 1'b1;
                end
            end else if (r_running) begin
                if (r_step_done <= r_step_target) begin
                    // pass step: drive pattern, move phase by direction mod 8
                    n_coil      = stp_pkg::HALF_STEP_TABLE[r_phase];
                    n_phase     = r_phase + {r_dir[1], r_dir};
                    n_step_done = r_step_done + stp_pkg::FIELD_W'(1);
                end else if (!r_reverse) begin
                    // turnaround
                    n_phase     = '0;
                    n_dir       = ~r_dir + 2'b01;
                    n_step_done = '0;
                    n_reverse   = 1'b1;
                end else begin
                    // end of reverse pass: coils off, back to idle
                    n_coil        = '0;
                    n_running     = 1'b0;
                    n_reverse     = 1'b0;
                    n_phase       = '0;
                    n_dir         = stp_pkg::DIR_ZERO;
                    n_step_target = '0;
                    n_step_done   = '0;
                end
            end
        end
    end

    assign o_result.coil_pattern = n_coil;
    assign o_result.busy_res     = n_running;
    assign o_result.accepted     = accepted;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running     <= 1'b0;
            r_reverse     <= 1'b0;
            r_phase       <= '0;
            r_dir         <= stp_pkg::DIR_ZERO;
            r_step_target <= '0;
            r_step_done   <= '0;
            r_coil        <= '0;
        end else begin
            r_running     <= n_running;
            r_reverse     <= n_reverse;
            r_phase       <= n_phase;
            r_dir         <= n_dir;
            r_step_target <= n_step_target;
            r_step_done   <= n_step_done;
            r_coil        <= n_coil;
        end
    end

endmodule

// File: hdl/stp_checker.sv
// stp_checker: port-level assertions for the half-step sequencer
// depends on stp_pkg; bound to stepper_half_step_out_and_back below
module stp_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  stp_pkg::t_out_item          i_out_item
);

    // result stays offered until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_item))
        else $error("result dropped or changed while stalled");

    // a started move always reports busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.accepted |-> i_out_item.busy_res)
        else $error("move accepted without busy");

    // coils are off whenever the sequencer is idle
    a_idle_coils: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_item.busy_res |-> i_out_item.coil_pattern == 4'd0)
        else $error("coils driven while idle");

    // only half-step table patterns or off reach the coils
    a_pattern: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> $countones(i_out_item.coil_pattern) <= 2
            && i_out_item.coil_pattern != 4'd5 && i_out_item.coil_pattern != 4'd10)
        else $error("illegal coil pattern");

    // reset empties the result register
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind stepper_half_step_out_and_back stp_checker u_stp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_item  (o_out_item)
);
